// ----- src/tal_pkg.sv -----
// tal_pkg: shared constants and types of the thruster allocation limiter
// no dependencies; used by the channel interfaces and the top level
package tal_pkg;

    localparam int unsigned Q_W      = 16;   // signed Q8.8 thrust and wrench words
    localparam int unsigned COEF_W   = 24;   // unsigned Q8.16 coefficient
    localparam int unsigned TOTAL_W  = 18;   // total limit and reported total
    localparam int unsigned SINGLE_W = 15;   // per-thruster clamp
    localparam int unsigned TICK_W   = 32;   // silence count and timeout
    localparam int unsigned CFG_W    = 32;   // config data port
    localparam int unsigned ACT_W    = 2;

    localparam int unsigned THR_CNT  = 6;
    localparam int unsigned AXIS_CNT = 5;

    typedef logic [ACT_W-1:0] t_action;
    typedef logic [2:0]       t_cfg_idx;

    localparam t_action ACT_WRENCH = 2'd0;
    localparam t_action ACT_HEART  = 2'd1;
    localparam t_action ACT_TICK   = 2'd2;

    localparam t_cfg_idx REG_SCALE_FX = 3'd0;
    localparam t_cfg_idx REG_SCALE_FY = 3'd1;
    localparam t_cfg_idx REG_SCALE_FZ = 3'd2;
    localparam t_cfg_idx REG_SCALE_TX = 3'd3;
    localparam t_cfg_idx REG_SCALE_TZ = 3'd4;
    localparam t_cfg_idx REG_TOTAL    = 3'd5;
    localparam t_cfg_idx REG_SINGLE   = 3'd6;
    localparam t_cfg_idx REG_TIMEOUT  = 3'd7;

    localparam logic [COEF_W-1:0]   SCALE_RST  = 24'd65536;
    localparam logic [TOTAL_W-1:0]  TOTAL_RST  = 18'd20480;  // 80 N
    localparam logic [SINGLE_W-1:0] SINGLE_RST = 15'd7680;   // 30 N

endpackage

// ----- src/tal_in_if.sv -----
// tal_in_if: command channel of the thruster allocation limiter
// depends on tal_pkg
interface tal_in_if;
    logic                                valid;
    logic                                ready;
    logic [tal_pkg::ACT_W-1:0]           action;
    logic signed [tal_pkg::Q_W-1:0]      force_x;
    logic signed [tal_pkg::Q_W-1:0]      force_y;
    logic signed [tal_pkg::Q_W-1:0]      force_z;
    logic signed [tal_pkg::Q_W-1:0]      torque_x;
    logic signed [tal_pkg::Q_W-1:0]      torque_z;
    logic                                heartbeat_alive;

    modport source (output valid, action, force_x, force_y, force_z, torque_x, torque_z,
                    heartbeat_alive, input ready);
    modport sink (input valid, action, force_x, force_y, force_z, torque_x, torque_z,
                  heartbeat_alive, output ready);
endinterface

// ----- src/tal_out_if.sv -----
// tal_out_if: result channel of the thruster allocation limiter
// depends on tal_pkg
interface tal_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [tal_pkg::Q_W-1:0]      thrust_front_right;
    logic signed [tal_pkg::Q_W-1:0]      thrust_front_left;
    logic signed [tal_pkg::Q_W-1:0]      thrust_vertical_left;
    logic signed [tal_pkg::Q_W-1:0]      thrust_vertical_right;
    logic signed [tal_pkg::Q_W-1:0]      thrust_rear_right;
    logic signed [tal_pkg::Q_W-1:0]      thrust_rear_left;
    logic [tal_pkg::TOTAL_W-1:0]         thrust_sum;
    logic                                timed_out;

    modport source (output valid, thrust_front_right, thrust_front_left, thrust_vertical_left,
                    thrust_vertical_right, thrust_rear_right, thrust_rear_left,
                    thrust_sum, timed_out, input ready);
    modport sink (input valid, thrust_front_right, thrust_front_left, thrust_vertical_left,
                  thrust_vertical_right, thrust_rear_right, thrust_rear_left,
                  thrust_sum, timed_out, output ready);
endinterface

// ----- src/thruster_allocation_limiter_unit.sv -----
// thruster_allocation_limiter_unit: six-thruster wrench mixer with total and single limits
// depends on tal_pkg, tal_in_if, tal_out_if
//
//  port      dir  kind          carries
//  i_cmd     in   valid/ready   wrench, heartbeat or tick word
//  o_res     out  valid/ready   six thrusts, total thrust, timed-out flag
//  i_cfg_*   in   write only    coefficient, limit and timeout registers
//
// heartbeat and tick words give no result
// a wrench is scaled, mixed and summed, then divided and renormalized when the total
// limit kicks in, then clamped: one shared multiplier does the five coefficient scalings
// and six renormalizations, and the 24-bit ratio comes from a one-bit-per-cycle divider
// a timed-out wrench skips the arithmetic; a finished result waits in the output
// register, and a new word is taken while it waits, until the next one is done
// reset is synchronous, active low, clears the sequencer, output valid and silence count, and loads config defaults
module thruster_allocation_limiter_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [2:0]                      i_cfg_idx,
    input  logic [tal_pkg::CFG_W-1:0]       i_cfg_data,
    tal_in_if.sink                          i_cmd,
    tal_out_if.source                       o_res
);

    localparam int unsigned SC_W   = 25;           // scaled component
    localparam int unsigned T_W    = 27;           // mixed thrust
    localparam int unsigned ACC_W  = 29;           // sum of magnitudes
    localparam int unsigned PROD_W = T_W + tal_pkg::COEF_W;
    localparam int unsigned DIV_STEPS = tal_pkg::COEF_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCL  = 3'd1;
    localparam logic [2:0] ST_MIX  = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_NRM  = 3'd5;
    localparam logic [2:0] ST_CLP  = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    // configuration
    logic [tal_pkg::COEF_W-1:0]   r_scale [tal_pkg::AXIS_CNT];
    logic [tal_pkg::TOTAL_W-1:0]  r_total_lim;
    logic [tal_pkg::SINGLE_W-1:0] r_single_lim;
    logic [tal_pkg::TICK_W-1:0]   r_timeout;
    logic [tal_pkg::TICK_W-1:0]   r_sil;

    // sequencer and datapath
    logic [2:0]                   r_state;
    logic [4:0]                   r_cnt;
    logic                         r_ph;
    logic                         r_tout;
    logic signed [tal_pkg::Q_W-1:0] r_wr  [tal_pkg::AXIS_CNT];
    logic signed [SC_W-1:0]       r_sc  [tal_pkg::AXIS_CNT];
    logic signed [T_W-1:0]        r_t   [tal_pkg::THR_CNT];
    logic signed [tal_pkg::Q_W-1:0] r_fin [tal_pkg::THR_CNT];
    logic [PROD_W-1:0]            r_prod;
    logic                         r_neg;
    logic [ACC_W-1:0]             r_acc;
    logic [ACC_W-1:0]             r_rem;
    logic [tal_pkg::COEF_W-1:0]   r_quo;

    // output register
    logic                         r_ovalid;
    logic signed [tal_pkg::Q_W-1:0] r_out_t [tal_pkg::THR_CNT];
    logic [tal_pkg::TOTAL_W-1:0]  r_out_total;
    logic                         r_out_tout;

    logic [2:0]                   n_idx;
    logic signed [T_W-1:0]        n_opd;
    logic                         n_neg;
    logic [T_W-1:0]               n_amag;
    logic [tal_pkg::COEF_W-1:0]   n_bop;
    logic [PROD_W:0]              n_pr;
    logic [T_W-1:0]               n_mag;
    logic signed [T_W-1:0]        n_scl;
    logic signed [T_W-1:0]        n_cur;
    logic [T_W-1:0]               n_cur_abs;
    logic [ACC_W-1:0]             n_acc;
    logic [ACC_W:0]               n_rem2;
    logic                         n_ge;
    logic signed [T_W-1:0]        n_lim;
    logic signed [T_W-1:0]        n_clp;
    logic [tal_pkg::Q_W-1:0]      n_clp_abs;
    logic signed [T_W-1:0]        n_x, n_y, n_z, n_r, n_w;
    logic                         n_acc_in;
    logic                         n_timed;
    logic                         n_load;

    assign n_idx    = r_cnt[2:0];
    assign n_acc_in = i_cmd.valid && i_cmd.ready;
    assign n_timed  = (r_timeout != '0) && (r_sil > r_timeout);
    assign n_load   = (r_state == ST_FIN) && (!r_ovalid || o_res.ready);

    // shared multiplier operands: magnitude times coefficient or ratio
    always_comb begin
        if (r_state == ST_SCL) begin
            n_opd = T_W'(r_wr[n_idx]);
            n_bop = r_scale[n_idx];
        end else begin
            n_opd = r_t[n_idx];
            n_bop = r_quo;
        end
        n_neg  = n_opd[T_W-1];
        n_amag = n_neg ? T_W'(-n_opd) : T_W'(n_opd);
    end

    // round to nearest, ties away from zero, on the magnitude
    always_comb begin
        if (r_state == ST_NRM) begin
            n_pr  = {1'b0, r_prod} + ((PROD_W+1)'(1) << 23);
            n_mag = n_pr[24 +: T_W];
        end else begin
            n_pr  = {1'b0, r_prod} + ((PROD_W+1)'(1) << 15);
            n_mag = n_pr[16 +: T_W];
        end
        n_scl = r_neg ? -signed'(n_mag) : signed'(n_mag);
    end

    // magnitude accumulate, divider step and clamp
    always_comb begin
        n_cur     = r_t[n_idx];
        n_cur_abs = n_cur[T_W-1] ? T_W'(-n_cur) : T_W'(n_cur);
        n_lim     = signed'(T_W'(r_single_lim));
        if (n_cur > n_lim) begin
            n_clp = n_lim;
        end else if (n_cur < -n_lim) begin
            n_clp = -n_lim;
        end else begin
            n_clp = n_cur;
        end
        n_clp_abs = n_clp[T_W-1] ? tal_pkg::Q_W'(-n_clp) : tal_pkg::Q_W'(n_clp);
        if (r_state == ST_CLP) begin
            n_acc = r_acc + ACC_W'(n_clp_abs);
        end else begin
            n_acc = r_acc + ACC_W'(n_cur_abs);
        end
        n_rem2 = {r_rem, 1'b0};
        n_ge   = n_rem2 >= {1'b0, r_acc};
    end

    // scaled components widened to the mixing width
    always_comb begin
        n_x = T_W'(r_sc[0]);
        n_y = T_W'(r_sc[1]);
        n_z = T_W'(r_sc[2]);
        n_r = T_W'(r_sc[3]);
        n_w = T_W'(r_sc[4]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < tal_pkg::AXIS_CNT; k++) begin
                r_scale[k] <= tal_pkg::SCALE_RST;
            end
            r_total_lim  <= tal_pkg::TOTAL_RST;
            r_single_lim <= tal_pkg::SINGLE_RST;
            r_timeout    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tal_pkg::REG_SCALE_FX,
                tal_pkg::REG_SCALE_FY,
                tal_pkg::REG_SCALE_FZ,
                tal_pkg::REG_SCALE_TX,
                tal_pkg::REG_SCALE_TZ: r_scale[i_cfg_idx] <= i_cfg_data[tal_pkg::COEF_W-1:0];
                tal_pkg::REG_TOTAL:   r_total_lim  <= i_cfg_data[tal_pkg::TOTAL_W-1:0];
                tal_pkg::REG_SINGLE:  r_single_lim <= i_cfg_data[tal_pkg::SINGLE_W-1:0];
                tal_pkg::REG_TIMEOUT: r_timeout    <= i_cfg_data[tal_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_ph    <= 1'b0;
            r_tout  <= 1'b0;
            r_sil   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (n_acc_in) begin
                        case (i_cmd.action)
                            tal_pkg::ACT_WRENCH: begin
                                r_tout  <= n_timed;
                                r_cnt   <= '0;
                                r_ph    <= 1'b0;
                                r_acc   <= '0;
                                r_state <= n_timed ? ST_FIN : ST_SCL;
                                r_wr[0] <= i_cmd.force_x;
                                r_wr[1] <= i_cmd.force_y;
                                r_wr[2] <= i_cmd.force_z;
                                r_wr[3] <= i_cmd.torque_x;
                                r_wr[4] <= i_cmd.torque_z;
                            end
                            tal_pkg::ACT_HEART: begin
                                if (i_cmd.heartbeat_alive) begin
                                    r_sil <= '0;
                                end
                            end
                            tal_pkg::ACT_TICK: begin
                                if (r_sil != '1) begin
                                    r_sil <= r_sil + 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCL: begin
                    if (!r_ph) begin
                        r_prod <= PROD_W'(n_amag * n_bop);
                        r_neg  <= n_neg;
                        r_ph   <= 1'b1;
                    end else begin
                        r_sc[n_idx] <= n_scl[SC_W-1:0];
                        r_ph        <= 1'b0;
                        if (n_idx == 3'(tal_pkg::AXIS_CNT - 1)) begin
                            r_cnt   <= '0;
                            r_state <= ST_MIX;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                ST_MIX: begin
                    r_t[0]  <= -n_x + n_y + n_w;   // front right
                    r_t[1]  <= -n_x - n_y - n_w;   // front left
                    r_t[2]  <=  n_z + n_r;         // vertical left
                    r_t[3]  <=  n_z - n_r;         // vertical right
                    r_t[4]  <=  n_x + n_y - n_w;   // rear right
                    r_t[5]  <=  n_x - n_y + n_w;   // rear left
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    if (n_idx == 3'(tal_pkg::THR_CNT - 1)) begin
                        r_cnt <= '0;
                        if (n_acc > ACC_W'(r_total_lim)) begin
                            // sum becomes the divisor, limit the first remainder
                            r_acc   <= n_acc;
                            r_rem   <= ACC_W'(r_total_lim);
                            r_quo   <= '0;
                            r_state <= ST_DIV;
                        end else begin
                            r_acc   <= '0;
                            r_state <= ST_CLP;
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                        r_acc <= n_acc;
                    end
                end
                ST_DIV: begin
                    r_rem <= n_ge ? ACC_W'(n_rem2 - {1'b0, r_acc}) : ACC_W'(n_rem2);
                    r_quo <= {r_quo[tal_pkg::COEF_W-2:0], n_ge};
                    if (r_cnt == 5'(DIV_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_ph    <= 1'b0;
                        r_state <= ST_NRM;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_NRM: begin
                    if (!r_ph) begin
                        r_prod <= PROD_W'(n_amag * n_bop);
                        r_neg  <= n_neg;
                        r_ph   <= 1'b1;
                    end else begin
                        r_t[n_idx] <= n_scl;
                        r_ph       <= 1'b0;
                        if (n_idx == 3'(tal_pkg::THR_CNT - 1)) begin
                            r_cnt   <= '0;
                            r_acc   <= '0;
                            r_state <= ST_CLP;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                ST_CLP: begin
                    r_fin[n_idx] <= n_clp[tal_pkg::Q_W-1:0];
                    r_acc        <= n_acc;
                    if (n_idx == 3'(tal_pkg::THR_CNT - 1)) begin
                        r_cnt   <= '0;
                        r_state <= ST_FIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_FIN: begin
                    if (n_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output register, refilled only once the previous word is gone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (n_load) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            for (int k = 0; k < tal_pkg::THR_CNT; k++) begin
                r_out_t[k] <= r_tout ? '0 : r_fin[k];
            end
            r_out_total <= r_tout ? '0 : r_acc[tal_pkg::TOTAL_W-1:0];
            r_out_tout  <= r_tout;
        end
    end

    assign i_cmd.ready                 = (r_state == ST_IDLE);
    assign o_res.valid                 = r_ovalid;
    assign o_res.thrust_front_right    = r_out_t[0];
    assign o_res.thrust_front_left     = r_out_t[1];
    assign o_res.thrust_vertical_left  = r_out_t[2];
    assign o_res.thrust_vertical_right = r_out_t[3];
    assign o_res.thrust_rear_right     = r_out_t[4];
    assign o_res.thrust_rear_left      = r_out_t[5];
    assign o_res.thrust_sum            = r_out_total;
    assign o_res.timed_out             = r_out_tout;

`ifndef SYNTHESIS
    // divider remainder stays below the divisor
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_acc))
        else $error("divider remainder not below divisor");

    // the ratio is only formed when the sum exceeds the limit
    a_div_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_acc > ACC_W'(r_total_lim)))
        else $error("division entered with sum within limit");

    // silence count only moves on an accepted word
    a_sil_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.valid && i_cmd.ready) |=> $stable(r_sil))
        else $error("silence count changed without a word");

    // a timed-out result carries a zero total thrust
    a_tout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.timed_out) |-> (o_res.thrust_sum == '0))
        else $error("timed-out result with nonzero total");

    // the summing, renormalizing and clamping phases never run past the thruster count
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM || r_state == ST_NRM || r_state == ST_CLP)
            |-> (r_cnt < 5'(tal_pkg::THR_CNT)))
        else $error("thruster index out of range");
`endif

endmodule
